// ===== sv/ey2q_pkg.sv =====
// ----------------------------------------------------------------------------
// ey2q_pkg
// Shared types and constants of the YXZ Euler angle to quaternion converter.
// ----------------------------------------------------------------------------
package ey2q_pkg;

   // Half angle circle in 1/128 degree units (same count as 360 deg in 1/64)
   localparam int FULL_TURN   = 23040;
   localparam int HALF_TURN   = 11520;
   localparam int OCTANT      = 5760;
   localparam int TURN_LOW    = 9;        // FULL_TURN = 45 << 9
   localparam int TURN_ODD    = 45;
   localparam int MOD_SHIFT   = 30;
   localparam int MOD_RECIP   = 23860930; // ceil(2^30 / 45)

   // radians per 1/128 degree, Q32
   localparam int RAD_PER_UNIT = 585635;

   localparam int TERMS = 6;

   // Series divisors split into a power of two and an odd part
   localparam int SIN_SHIFT [TERMS] = '{1, 2, 1, 3, 1, 2};
   localparam int SIN_ODD   [TERMS] = '{3, 5, 21, 9, 55, 39};
   localparam int COS_SHIFT [TERMS] = '{1, 2, 1, 3, 1, 2};
   localparam int COS_ODD   [TERMS] = '{1, 3, 15, 7, 45, 33};

   localparam int REDUCE_LAT = 4;
   localparam int TERM_LAT   = 4;
   localparam int SINCOS_LAT = 2 + TERMS * TERM_LAT + 1;
   localparam int QUAT_LAT   = 6;

   typedef struct packed {
      logic upper;   // half angle in [90, 180) degrees
      logic swap;    // octant mirrored: sine and cosine exchanged
   } fold_type;

endpackage

// ===== sv/ey2q_reduce.sv =====
// ----------------------------------------------------------------------------
// ey2q_reduce
// Reduces one angle modulo the full turn and folds it onto the first octant.
// ----------------------------------------------------------------------------
module ey2q_reduce #(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [ANGLE_WIDTH-1:0] angle,
   output logic                   out_valid,
   output logic [12:0]            out_u,
   output ey2q_pkg::fold_type     out_fold
);

   localparam int UW = (ANGLE_WIDTH + 1 > 17) ? ANGLE_WIDTH + 1 : 17;
   localparam int NB = UW - ey2q_pkg::TURN_LOW;
   localparam longint OFF_L = ((64'd1 << (ANGLE_WIDTH - 1)) + ey2q_pkg::FULL_TURN - 1)
                              / ey2q_pkg::FULL_TURN * ey2q_pkg::FULL_TURN;
   localparam logic [UW-1:0] OFF = UW'(OFF_L);
   localparam logic [24:0] RECIP = 25'(ey2q_pkg::MOD_RECIP);

   logic [2:0]    valid_ff, valid_in;
   logic [UW-1:0] ua_ff, ua_in;
   logic [UW-1:0] ua2_ff;
   logic [NB-1:0] q_ff, q_in;
   logic [NB+24:0] q_prod;
   logic [NB-1:0] n2, rem, rem_fix;
   logic [14:0]   h_ff, h_in;
   logic [13:0]   g;
   logic          upper;
   logic [12:0]   u_ff, u_in;
   ey2q_pkg::fold_type fold_ff, fold_in;
   logic          out_valid_ff;

   // offset by a multiple of the turn so the value is never negative
   assign ua_in = {{(UW - ANGLE_WIDTH){angle[ANGLE_WIDTH-1]}}, angle} + OFF;

   assign q_prod = (NB + 25)'(ua_ff[UW-1:ey2q_pkg::TURN_LOW]) * (NB + 25)'(RECIP);
   assign q_in   = NB'(q_prod >> ey2q_pkg::MOD_SHIFT);

   assign n2      = ua2_ff[UW-1:ey2q_pkg::TURN_LOW];
   assign rem     = n2 - NB'(q_ff * NB'(ey2q_pkg::TURN_ODD));
   assign rem_fix = (rem >= NB'(ey2q_pkg::TURN_ODD)) ? rem - NB'(ey2q_pkg::TURN_ODD) : rem;
   assign h_in    = {6'(rem_fix), ua2_ff[ey2q_pkg::TURN_LOW-1:0]};

   always_comb begin
      upper = (h_ff >= 15'(ey2q_pkg::HALF_TURN));
      g     = upper ? 14'(h_ff - 15'(ey2q_pkg::HALF_TURN)) : h_ff[13:0];
      fold_in.upper = upper;
      fold_in.swap  = (g > 14'(ey2q_pkg::OCTANT));
      u_in  = fold_in.swap ? 13'(14'(ey2q_pkg::HALF_TURN) - g) : g[12:0];
   end

   assign valid_in = {valid_ff[1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         out_valid_ff <= valid_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      ua_ff   <= ua_in;
      ua2_ff  <= ua_ff;
      q_ff    <= q_in;
      h_ff    <= h_in;
      u_ff    <= u_in;
      fold_ff <= fold_in;
   end

   assign out_valid = out_valid_ff;
   assign out_u     = u_ff;
   assign out_fold  = fold_ff;

endmodule

// ===== sv/ey2q_term.sv =====
// ----------------------------------------------------------------------------
// ey2q_term
// One Taylor series step: next term = floor(floor(term * x2 / 2^32) / div),
// added to or subtracted from the running sum. Four register stages.
// ----------------------------------------------------------------------------
module ey2q_term #(
   parameter int SHIFT  = 1,
   parameter int ODD    = 3,
   parameter int NEGATE = 1
) (
   input  logic               clock,
   input  logic [32:0]        term_in,
   input  logic signed [34:0] sum_in,
   input  logic [31:0]        x2_in,
   output logic [32:0]        term_out,
   output logic signed [34:0] sum_out,
   output logic [31:0]        x2_out
);

   localparam longint RECIP_L = (64'd1 << 32) / ODD;
   localparam logic [32:0] RECIP = 33'(RECIP_L);

   logic [64:0]        prod_a;
   logic [31:0]        p_a_ff;
   logic signed [34:0] sum_a_ff, sum_b_ff, sum_c_ff, sum_d_ff;
   logic [31:0]        x2_a_ff, x2_b_ff, x2_c_ff, x2_d_ff;
   logic [31:0]        n_b, n_b_ff;
   logic [64:0]        prod_b;
   logic [31:0]        q0_b_ff;
   logic [31:0]        r_c;
   logic [31:0]        q_c_ff, q_c_in;
   logic [32:0]        term_d_ff;

   assign prod_a = 65'(term_in) * 65'(x2_in);
   assign n_b    = p_a_ff >> SHIFT;
   assign prod_b = 65'(n_b) * 65'(RECIP);

   // reciprocal estimate is low by at most one
   assign r_c    = n_b_ff - 32'(q0_b_ff * 32'(ODD));
   assign q_c_in = (r_c >= 32'(ODD)) ? q0_b_ff + 32'd1 : q0_b_ff;

   always_ff @(posedge clock) begin
      p_a_ff   <= prod_a[63:32];
      sum_a_ff <= sum_in;
      x2_a_ff  <= x2_in;

      n_b_ff   <= n_b;
      q0_b_ff  <= prod_b[63:32];
      sum_b_ff <= sum_a_ff;
      x2_b_ff  <= x2_a_ff;

      q_c_ff   <= q_c_in;
      sum_c_ff <= sum_b_ff;
      x2_c_ff  <= x2_b_ff;

      term_d_ff <= {1'b0, q_c_ff};
      sum_d_ff  <= (NEGATE != 0) ? sum_c_ff - 35'(q_c_ff) : sum_c_ff + 35'(q_c_ff);
      x2_d_ff   <= x2_c_ff;
   end

   assign term_out = term_d_ff;
   assign sum_out  = sum_d_ff;
   assign x2_out   = x2_d_ff;

endmodule

// ===== sv/ey2q_sincos.sv =====
// ----------------------------------------------------------------------------
// ey2q_sincos
// Sine and cosine (Q30) of a folded half angle, with the octant and
// quadrant unfolding applied at the end.
// ----------------------------------------------------------------------------
module ey2q_sincos (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [12:0]        in_u,
   input  ey2q_pkg::fold_type in_fold,
   output logic               out_valid,
   output logic signed [31:0] out_sin,
   output logic signed [31:0] out_cos
);

   localparam int DL = 2 + ey2q_pkg::TERMS * ey2q_pkg::TERM_LAT;

   logic               vpipe_ff [DL];
   ey2q_pkg::fold_type fpipe_ff [DL];

   logic [31:0] x_ff, x_d_ff, x2_ff;
   logic [63:0] x_sq;

   logic [32:0]        s_term [ey2q_pkg::TERMS+1];
   logic signed [34:0] s_sum  [ey2q_pkg::TERMS+1];
   logic [31:0]        s_x2   [ey2q_pkg::TERMS+1];
   logic [32:0]        c_term [ey2q_pkg::TERMS+1];
   logic signed [34:0] c_sum  [ey2q_pkg::TERMS+1];
   logic [31:0]        c_x2   [ey2q_pkg::TERMS+1];

   logic signed [34:0] s_cl, c_cl;
   logic signed [31:0] sg, cg;
   logic signed [31:0] sin_ff, sin_in, cos_ff, cos_in;
   logic               out_valid_ff;
   ey2q_pkg::fold_type fl;

   assign x_sq = 64'(x_ff) * 64'(x_ff);

   always_ff @(posedge clock) begin
      x_ff   <= 32'(in_u) * 32'(ey2q_pkg::RAD_PER_UNIT);
      x_d_ff <= x_ff;
      x2_ff  <= x_sq[63:32];
   end

   assign s_term[0] = {1'b0, x_d_ff};
   assign s_sum[0]  = 35'(x_d_ff);
   assign s_x2[0]   = x2_ff;
   assign c_term[0] = 33'h1_0000_0000;
   assign c_sum[0]  = 35'sh1_0000_0000;
   assign c_x2[0]   = x2_ff;

   for (genvar k = 0; k < ey2q_pkg::TERMS; k++) begin : g_series
      ey2q_term #(
         .SHIFT  (ey2q_pkg::SIN_SHIFT[k]),
         .ODD    (ey2q_pkg::SIN_ODD[k]),
         .NEGATE ((k % 2 == 0) ? 1 : 0)
      ) u_sin (
         .clock    (clock),
         .term_in  (s_term[k]),
         .sum_in   (s_sum[k]),
         .x2_in    (s_x2[k]),
         .term_out (s_term[k+1]),
         .sum_out  (s_sum[k+1]),
         .x2_out   (s_x2[k+1])
      );
      ey2q_term #(
         .SHIFT  (ey2q_pkg::COS_SHIFT[k]),
         .ODD    (ey2q_pkg::COS_ODD[k]),
         .NEGATE ((k % 2 == 0) ? 1 : 0)
      ) u_cos (
         .clock    (clock),
         .term_in  (c_term[k]),
         .sum_in   (c_sum[k]),
         .x2_in    (c_x2[k]),
         .term_out (c_term[k+1]),
         .sum_out  (c_sum[k+1]),
         .x2_out   (c_x2[k+1])
      );
   end

   // clamp, round to Q30, then undo the octant mirror and the quadrant
   always_comb begin
      fl   = fpipe_ff[DL-1];
      s_cl = s_sum[ey2q_pkg::TERMS][34] ? '0 : s_sum[ey2q_pkg::TERMS];
      c_cl = c_sum[ey2q_pkg::TERMS][34] ? '0 : c_sum[ey2q_pkg::TERMS];
      sg   = 32'((s_cl + 35'sd2) >>> 2);
      cg   = 32'((c_cl + 35'sd2) >>> 2);
      if (fl.swap) begin
         sg = 32'((c_cl + 35'sd2) >>> 2);
         cg = 32'((s_cl + 35'sd2) >>> 2);
      end
      if (fl.upper) begin
         sin_in = cg;
         cos_in = -sg;
      end else begin
         sin_in = sg;
         cos_in = cg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DL; i++) vpipe_ff[i] <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         vpipe_ff[0] <= in_valid;
         for (int i = 1; i < DL; i++) vpipe_ff[i] <= vpipe_ff[i-1];
         out_valid_ff <= vpipe_ff[DL-1];
      end
   end

   always_ff @(posedge clock) begin
      fpipe_ff[0] <= in_fold;
      for (int i = 1; i < DL; i++) fpipe_ff[i] <= fpipe_ff[i-1];
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

   assign out_valid = out_valid_ff;
   assign out_sin   = sin_ff;
   assign out_cos   = cos_ff;

endmodule

// ===== sv/ey2q_quat.sv =====
// ----------------------------------------------------------------------------
// ey2q_quat
// Quaternion product qy*qx*qz from half angle sines and cosines, sign
// canonicalization, rounding and saturation.
// ----------------------------------------------------------------------------
module ey2q_quat #(
   parameter int QUAT_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic signed [31:0]    sy,
   input  logic signed [31:0]    cy,
   input  logic signed [31:0]    sx,
   input  logic signed [31:0]    cx,
   input  logic signed [31:0]    sz,
   input  logic signed [31:0]    cz,
   output logic                  out_valid,
   output logic [QUAT_WIDTH-1:0] quat_w,
   output logic [QUAT_WIDTH-1:0] quat_x,
   output logic [QUAT_WIDTH-1:0] quat_y,
   output logic [QUAT_WIDTH-1:0] quat_z
);

   localparam int SH = 61 - QUAT_WIDTH;
   localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (SH - 1);
   localparam logic signed [63:0] HI = (64'sd1 <<< (QUAT_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] LO = -HI - 64'sd1;

   logic [5:0] valid_ff;

   logic signed [31:0] sz1_ff, cz1_ff, sz2_ff, cz2_ff;
   logic signed [63:0] p_cc_ff, p_ss_ff, p_cs_ff, p_sc_ff;
   logic signed [32:0] r_cc_ff, r_ss_ff, r_cs_ff, r_sc_ff;
   logic signed [63:0] m_ff [8];
   logic signed [63:0] v_ff [4];
   logic signed [63:0] n_ff [4];
   logic signed [63:0] rnd  [4];
   logic [QUAT_WIDTH-1:0] q_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      p_cc_ff <= cy * cx;
      p_ss_ff <= sy * sx;
      p_cs_ff <= cy * sx;
      p_sc_ff <= sy * cx;
      sz1_ff  <= sz;
      cz1_ff  <= cz;

      r_cc_ff <= 33'((p_cc_ff + 64'sd536870912) >>> 30);
      r_ss_ff <= 33'((p_ss_ff + 64'sd536870912) >>> 30);
      r_cs_ff <= 33'((p_cs_ff + 64'sd536870912) >>> 30);
      r_sc_ff <= 33'((p_sc_ff + 64'sd536870912) >>> 30);
      sz2_ff  <= sz1_ff;
      cz2_ff  <= cz1_ff;

      m_ff[0] <= r_cc_ff * cz2_ff;   // w
      m_ff[1] <= r_ss_ff * sz2_ff;
      m_ff[2] <= r_cs_ff * cz2_ff;   // x
      m_ff[3] <= r_sc_ff * sz2_ff;
      m_ff[4] <= r_sc_ff * cz2_ff;   // y
      m_ff[5] <= r_cs_ff * sz2_ff;
      m_ff[6] <= r_cc_ff * sz2_ff;   // z
      m_ff[7] <= r_ss_ff * cz2_ff;

      v_ff[0] <= m_ff[0] + m_ff[1];
      v_ff[1] <= m_ff[2] + m_ff[3];
      v_ff[2] <= m_ff[4] - m_ff[5];
      v_ff[3] <= m_ff[6] - m_ff[7];

      // keep w nonnegative; zero is left alone
      for (int i = 0; i < 4; i++) n_ff[i] <= v_ff[0][63] ? -v_ff[i] : v_ff[i];

      for (int i = 0; i < 4; i++) begin
         if (rnd[i] > HI) begin
            q_ff[i] <= QUAT_WIDTH'(HI);
         end else if (rnd[i] < LO) begin
            q_ff[i] <= QUAT_WIDTH'(LO);
         end else begin
            q_ff[i] <= QUAT_WIDTH'(rnd[i]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) rnd[i] = (n_ff[i] + HALF_LSB) >>> SH;
   end

   assign out_valid = valid_ff[5];
   assign quat_w    = q_ff[0];
   assign quat_x    = q_ff[1];
   assign quat_y    = q_ff[2];
   assign quat_z    = q_ff[3];

endmodule

// ===== sv/euler_yxz_to_quaternion_core.sv =====
// ----------------------------------------------------------------------------
// euler_yxz_to_quaternion_core
// Euler angles (Y, X, Z order, 1/64 degree) to a canonical unit quaternion.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_angle_y/x/z and pulse start; a request is taken at each clock
//   edge with start high and busy low. busy is only high during reset, so a
//   new request can be issued every cycle.
//   Each result appears on rsp_quat_w/x/y/z for one cycle with rsp_valid
//   high, in request order.
//   Pipeline: angle reduction (modulo-45 reciprocal multiply and octant
//   fold), sine/cosine (six Taylor terms of four stages each, with a
//   reciprocal multiply for each series divisor), then quaternion product
//   and output rounding.
//   Throughput: one request per cycle outside reset.
//   Reset clears all valid bits; requests in flight are dropped.
//   Results cannot be held off: rsp_valid is a strobe and the sink must take
//   the result in that cycle.
// ----------------------------------------------------------------------------
module euler_yxz_to_quaternion_core #(
   parameter int ANGLE_WIDTH = 16,
   parameter int QUAT_WIDTH  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [ANGLE_WIDTH-1:0] req_angle_y,
   input  logic [ANGLE_WIDTH-1:0] req_angle_x,
   input  logic [ANGLE_WIDTH-1:0] req_angle_z,
   output logic                   rsp_valid,
   output logic [QUAT_WIDTH-1:0]  rsp_quat_w,
   output logic [QUAT_WIDTH-1:0]  rsp_quat_x,
   output logic [QUAT_WIDTH-1:0]  rsp_quat_y,
   output logic [QUAT_WIDTH-1:0]  rsp_quat_z
);

   localparam int LAT = ey2q_pkg::REDUCE_LAT + ey2q_pkg::SINCOS_LAT + ey2q_pkg::QUAT_LAT;

   logic               req_take;
   logic [2:0]         red_valid, sc_valid;
   logic [12:0]        red_u [3];
   ey2q_pkg::fold_type red_fold [3];
   logic signed [31:0] sn [3];
   logic signed [31:0] cs [3];
   logic [ANGLE_WIDTH-1:0] ang [3];

   assign busy     = reset;
   assign req_take = start && !busy;

   assign ang[0] = req_angle_y;
   assign ang[1] = req_angle_x;
   assign ang[2] = req_angle_z;

   for (genvar i = 0; i < 3; i++) begin : g_axis
      ey2q_reduce #(
         .ANGLE_WIDTH (ANGLE_WIDTH)
      ) u_reduce (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (req_take),
         .angle     (ang[i]),
         .out_valid (red_valid[i]),
         .out_u     (red_u[i]),
         .out_fold  (red_fold[i])
      );
      ey2q_sincos u_sincos (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (red_valid[i]),
         .in_u      (red_u[i]),
         .in_fold   (red_fold[i]),
         .out_valid (sc_valid[i]),
         .out_sin   (sn[i]),
         .out_cos   (cs[i])
      );
   end

   ey2q_quat #(
      .QUAT_WIDTH (QUAT_WIDTH)
   ) u_quat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sc_valid[0]),
      .sy        (sn[0]),
      .cy        (cs[0]),
      .sx        (sn[1]),
      .cx        (cs[1]),
      .sz        (sn[2]),
      .cz        (cs[2]),
      .out_valid (rsp_valid),
      .quat_w    (rsp_quat_w),
      .quat_x    (rsp_quat_x),
      .quat_y    (rsp_quat_y),
      .quat_z    (rsp_quat_z)
   );

`ifndef SYNTH
   a_latency : assert property (@(posedge clock) disable iff (reset)
      req_take |-> ##LAT rsp_valid)
      else $error("request did not produce a result at the expected latency");

   a_w_nonneg : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_quat_w[QUAT_WIDTH-1])
      else $error("scalar part of result is negative");

   a_lanes_aligned : assert property (@(posedge clock) disable iff (reset)
      sc_valid[0] |-> (sc_valid[1] && sc_valid[2]))
      else $error("sine/cosine lanes out of step");
`endif

endmodule

// ===== tb/sv/euler_yxz_to_quaternion_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_yxz_to_quaternion_core_tb
// Drives YXZ Euler angle requests (a directed table, then random angles) into
// the converter, predicts each quaternion with a bit-exact fixed-point model
// and compares every strobed result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module euler_yxz_to_quaternion_core_tb;

   localparam int AW = 16;
   localparam int QW = 16;
   localparam int N_RANDOM = 530;
   localparam int WATCHDOG = 2000;
   localparam int DRAIN = 60;
   localparam longint TURN = 23040;
   localparam longint HALF = 11520;
   localparam longint OCT = 5760;
   localparam longint RAD_Q32 = 585635;

   typedef struct packed {
      logic [QW-1:0] w;
      logic [QW-1:0] x;
      logic [QW-1:0] y;
      logic [QW-1:0] z;
   } quat_type;

   typedef struct {
      logic [AW-1:0] ay;
      logic [AW-1:0] ax;
      logic [AW-1:0] az;
      logic          known;
      quat_type      q;
   } dir_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   logic [AW-1:0] req_angle_y = '0;
   logic [AW-1:0] req_angle_x = '0;
   logic [AW-1:0] req_angle_z = '0;
   logic          rsp_valid;
   logic [QW-1:0] rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;

   quat_type quat_pending[$];
   int       n_errors = 0;
   int       idle_cycles = 0;

   euler_yxz_to_quaternion_core #(.ANGLE_WIDTH(AW), .QUAT_WIDTH(QW)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_angle_y(req_angle_y), .req_angle_x(req_angle_x),
      .req_angle_z(req_angle_z), .rsp_valid(rsp_valid),
      .rsp_quat_w(rsp_quat_w), .rsp_quat_x(rsp_quat_x),
      .rsp_quat_y(rsp_quat_y), .rsp_quat_z(rsp_quat_z)
   );

   always #1 clock = ~clock;

   // ---------------- predictor ----------------
   function automatic longint rshift_round(longint v, int n);
      longint q;
      q = (v + (longint'(1) << (n - 1))) >>> n;
      return q;
   endfunction

   // Q30 sine/cosine of octant angle u in [0, 5760] (1/128 deg)
   function automatic void octant_trig(longint u, output longint s_q30,
                                       output longint c_q30);
      logic [63:0]  xr, x2, ts, tc;
      logic [127:0] p;
      longint       s, c;
      xr = u * RAD_Q32;
      p  = xr * xr;
      x2 = p[95:32];
      ts = xr;
      tc = 64'd1 << 32;
      s  = longint'(xr);
      c  = longint'(tc);
      for (int k = 1; k <= 6; k++) begin
         p  = ts * x2;
         ts = p[95:32] / ((2 * k) * (2 * k + 1));
         p  = tc * x2;
         tc = p[95:32] / ((2 * k - 1) * (2 * k));
         if (k % 2 == 1) begin
            s -= longint'(ts);
            c -= longint'(tc);
         end else begin
            s += longint'(ts);
            c += longint'(tc);
         end
      end
      if (s < 0) s = 0;
      if (c < 0) c = 0;
      s_q30 = (s + 2) >>> 2;
      c_q30 = (c + 2) >>> 2;
   endfunction

   function automatic void half_trig(logic [AW-1:0] raw, output longint sn,
                                     output longint cs);
      longint h, g, sg, cg;
      logic   upper;
      h = longint'($signed(raw)) % TURN;
      if (h < 0) h += TURN;
      upper = (h >= HALF);
      g = upper ? h - HALF : h;
      if (g <= OCT) octant_trig(g, sg, cg);
      else          octant_trig(HALF - g, cg, sg);
      if (upper) begin
         sn = cg;
         cs = -sg;
      end else begin
         sn = sg;
         cs = cg;
      end
   endfunction

   function automatic longint prod3(longint a, longint b, longint c);
      return rshift_round(a * b, 30) * c;
   endfunction

   function automatic logic [QW-1:0] q60_to_out(longint v);
      longint r, hi;
      hi = (longint'(1) << (QW - 1)) - 1;
      r = rshift_round(v, 61 - QW);
      if (r > hi) r = hi;
      if (r < -hi - 1) r = -hi - 1;
      return r[QW-1:0];
   endfunction

   function automatic quat_type yxz_quat(logic [AW-1:0] ay, logic [AW-1:0] ax,
                                         logic [AW-1:0] az);
      longint   sy, cy, sx, cx, sz, cz, w, x, y, z;
      quat_type q;
      half_trig(ay, sy, cy);
      half_trig(ax, sx, cx);
      half_trig(az, sz, cz);
      w = prod3(cy, cx, cz) + prod3(sy, sx, sz);
      x = prod3(cy, sx, cz) + prod3(sy, cx, sz);
      y = prod3(sy, cx, cz) - prod3(cy, sx, sz);
      z = prod3(cy, cx, sz) - prod3(sy, sx, cz);
      if (w < 0) begin
         w = -w; x = -x; y = -y; z = -z;
      end
      q.w = q60_to_out(w);
      q.x = q60_to_out(x);
      q.y = q60_to_out(y);
      q.z = q60_to_out(z);
      return q;
   endfunction

   // ---------------- checking ----------------
   task automatic report_mismatch(string what, logic [QW-1:0] got,
                                  logic [QW-1:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      n_errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         quat_type e;
         if (quat_pending.size() == 0) begin
            report_mismatch("unexpected result", rsp_quat_w, '0);
         end else begin
            e = quat_pending.pop_front();
            if (rsp_quat_w !== e.w) report_mismatch("quat_w", rsp_quat_w, e.w);
            if (rsp_quat_x !== e.x) report_mismatch("quat_x", rsp_quat_x, e.x);
            if (rsp_quat_y !== e.y) report_mismatch("quat_y", rsp_quat_y, e.y);
            if (rsp_quat_z !== e.z) report_mismatch("quat_z", rsp_quat_z, e.z);
         end
      end
   end

   // watchdog: cycles without any handshake
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("watchdog expired");
         $display("FAIL euler_yxz_to_quaternion_core");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   dir_row_type dir_rows[$];

   function automatic logic [AW-1:0] rand_angle();
      case ($urandom_range(0, 5))
         0: return AW'(32'h8000 + $urandom_range(0, 3));
         1: return AW'(32'h7fff - $urandom_range(0, 3));
         2: return AW'($urandom_range(0, 64 * 360));     // within one turn
         3: return AW'(32'd0 - $urandom_range(0, 64 * 360));
         4: return AW'(64 * 90 * $urandom_range(0, 4) + $urandom_range(0, 2) - 1);
         default: return AW'($urandom());
      endcase
   endfunction

   // one request: hold until taken, optional gap burst afterwards
   task automatic send_request(logic [AW-1:0] ay, logic [AW-1:0] ax,
                               logic [AW-1:0] az, logic gaps);
      req_angle_y <= ay;
      req_angle_x <= ax;
      req_angle_z <= az;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      quat_pending.push_back(yxz_quat(ay, ax, az));
      @(negedge clock);
      if (gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
   endtask

   task automatic add_row(int ay, int ax, int az, logic known = 1'b0,
                          quat_type q = '0);
      dir_row_type r;
      r.ay = AW'(ay); r.ax = AW'(ax); r.az = AW'(az); r.known = known; r.q = q;
      dir_rows.push_back(r);
   endtask

   initial begin
      quat_type ident;
      ident = '{w: 16'h7fff, x: 16'h0, y: 16'h0, z: 16'h0};
      // zero and full turns give the identity (w saturates)
      add_row(0, 0, 0, 1'b1, ident);
      add_row(23040, 0, 0, 1'b1, ident);
      add_row(-23040, -23040, 23040, 1'b1, ident);
      add_row(16'h7fff, 16'h7fff, 16'h7fff);
      add_row(16'h8000, 16'h8000, 16'h8000);
      add_row(16'hffff, 1, 16'hffff);
      add_row(11520, 0, 0);                 // 180 deg: w exactly zero
      add_row(0, 11520, 0);
      add_row(0, 0, 11520);
      add_row(11521, 0, 0);                 // just past: w negative, flipped
      add_row(5760, 0, 0);
      add_row(0, 5760, 0);
      add_row(0, 0, 5760);
      add_row(5759, 5761, 17280);
      add_row(2880, 2881, 2879);            // middle of the first octant
      add_row(-5760, 5760, -5760);
      add_row(5760, 5760, 5760);
      add_row(17281, -17281, 11519);
      add_row(16'h5555, 16'haaaa, 16'h1234);
      add_row(16'haaaa, 16'h5555, 16'hedcb);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].known && yxz_quat(dir_rows[i].ay, dir_rows[i].ax,
                                            dir_rows[i].az) != dir_rows[i].q)
            report_mismatch("table row", '0, dir_rows[i].q.w);
         send_request(dir_rows[i].ay, dir_rows[i].ax, dir_rows[i].az, 1'b1);
      end
      for (int n = 0; n < N_RANDOM; n++)
         send_request(rand_angle(), rand_angle(), rand_angle(),
                      n < N_RANDOM - 80);
      start <= 1'b0;

      while (quat_pending.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (n_errors == 0)
         $display("PASS euler_yxz_to_quaternion_core");
      else
         $display("FAIL euler_yxz_to_quaternion_core");
      $finish;
   end

endmodule
